// ===== design/phpfc_pkg.sv =====
// Shared types, constants and the FNV-1a fold for the packet header parser.
// Used by phpfc_ctrl, phpfc_dp and packet_header_parse_fnv_check; no dependencies.
package phpfc_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned COUNT_W    = 33;
    localparam int unsigned POS_W      = 4;
    localparam int unsigned STATUS_W   = 3;
    localparam int unsigned M_TDATA_W  = 24;

    localparam logic [POS_W-1:0] HDR_BYTES   = 4'd14;
    localparam logic [POS_W-1:0] POS_VERSION = 4'd4;
    localparam logic [POS_W-1:0] POS_TYPE    = 4'd5;
    localparam logic [POS_W-1:0] POS_LENGTH  = 4'd6;
    localparam logic [POS_W-1:0] POS_CHECK   = 4'd10;

    localparam logic [WORD_W-1:0]  MAGIC_WORD  = 32'h4f52544d;
    localparam logic [WORD_W-1:0]  FNV_BASIS   = 32'd2166136261;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};
    localparam logic [BYTE_W-1:0]  VERSION_RST = 8'd1;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_TRUNCATED = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_MAGIC = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_BAD_VER   = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_BAD_LEN   = 3'd4;
    localparam logic [STATUS_W-1:0] STATUS_BAD_SUM   = 3'd5;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;          // input transaction accepted this cycle
        logic fold_version;  // second header fold: the version byte
        logic load_verdict;  // load the verdict into the output register
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic at_type;       // the next header byte is the type byte
        logic out_free;      // output register empty or draining this cycle
    } dp_status_t;

    // One FNV-1a step. The prime is 2^24 + 403, so the product reduces to shifts and adds.
    function automatic logic [WORD_W-1:0] fnv_fold(input logic [WORD_W-1:0] h,
                                                  input logic [BYTE_W-1:0] b);
        logic [WORD_W-1:0] x;
        begin
            x = h ^ {{(WORD_W-BYTE_W){1'b0}}, b};
            fnv_fold = (x << 24) + (x << 8) + (x << 7) + (x << 4) + (x << 1) + x;
        end
    endfunction

endpackage

// ===== design/phpfc_ctrl.sv =====
// Controller state machine for the packet header parser.
// Depends on phpfc_pkg; drives the datapath phpfc_dp through command signals.
module phpfc_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tlast,
    output logic                   s_tready,
    input  phpfc_pkg::dp_status_t  dp_status,
    output phpfc_pkg::ctrl_cmd_t   cmd
);
    import phpfc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_FOLD = 3'b010,
        S_VERD = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   fin_reg, fin_next;
    logic   accept;

    assign s_tready = (state_reg == S_IDLE) && dp_status.out_free;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        state_next       = state_reg;
        fin_next         = fin_reg;
        cmd.take         = 1'b0;
        cmd.fold_version = 1'b0;
        cmd.load_verdict = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.take = accept;
                if (accept)
                begin
                    fin_next = s_tlast;
                    if (dp_status.at_type)
                        state_next = S_FOLD;
                    else if (s_tlast)
                        state_next = S_VERD;
                end
            end
            S_FOLD:
            begin
                cmd.fold_version = 1'b1;
                state_next       = fin_reg ? S_VERD : S_IDLE;
            end
            S_VERD:
            begin
                if (dp_status.out_free)
                begin
                    cmd.load_verdict = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fin_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
        end
    end

`ifndef SYNTH
    // The second fold always directly follows the transaction that carried the type byte.
    a_fold_after_type: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fold_version |-> $past(cmd.take) && $past(dp_status.at_type))
        else $error("version fold without a preceding type byte");

    // Input is never taken while a verdict is still owed.
    a_no_take_in_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_VERD) |-> !s_tready)
        else $error("input accepted while verdict pending");
`endif

endmodule

// ===== design/phpfc_dp.sv =====
// Datapath for the packet header parser: header fields, FNV-1a hash, payload
// counter, verdict logic and the output register. Depends on phpfc_pkg.
module phpfc_dp (
    input  logic                   clk,
    input  logic                   rst_n,
    input  phpfc_pkg::ctrl_cmd_t   cmd,
    output phpfc_pkg::dp_status_t  dp_status,
    input  logic [7:0]             s_tdata,
    input  logic                   s_tlast,
    input  logic                   cfg_wr_en,
    input  logic [7:0]             cfg_wr_data,
    input  logic                   m_tready,
    output logic                   m_tvalid,
    output logic [23:0]            m_tdata,
    output logic                   m_tuser,
    output logic                   m_tlast
);
    import phpfc_pkg::*;

    logic [BYTE_W-1:0]   exp_ver_reg;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [WORD_W-1:0]   magic_reg, magic_next;
    logic [BYTE_W-1:0]   ver_reg, ver_next;
    logic [BYTE_W-1:0]   type_reg, type_next;
    logic [WORD_W-1:0]   len_reg, len_next;
    logic [WORD_W-1:0]   sum_reg, sum_next;
    logic [WORD_W-1:0]   hash_reg, hash_next;
    logic [COUNT_W-1:0]  count_reg, count_next;

    logic                out_valid_reg, out_valid_next;
    logic                out_kind_reg, out_kind_next;
    logic [BYTE_W-1:0]   out_byte_reg, out_byte_next;
    logic [BYTE_W-1:0]   out_type_reg, out_type_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic                out_last_reg, out_last_next;

    logic                in_header;
    logic                take_payload;
    logic [STATUS_W-1:0] verdict_status;
    logic [BYTE_W-1:0]   verdict_type;

    assign in_header    = (pos_reg < HDR_BYTES);
    assign take_payload = cmd.take && !in_header;

    assign dp_status.at_type  = (pos_reg == POS_TYPE);
    assign dp_status.out_free = !out_valid_reg || m_tready;

    // Checks in priority order; the header position is already final here.
    always_comb
    begin
        verdict_type = type_reg;
        if (in_header)
        begin
            verdict_status = STATUS_TRUNCATED;
            verdict_type   = '0;
        end
        else if (magic_reg != MAGIC_WORD)
            verdict_status = STATUS_BAD_MAGIC;
        else if (ver_reg != exp_ver_reg)
            verdict_status = STATUS_BAD_VER;
        else if (count_reg != {1'b0, len_reg})
            verdict_status = STATUS_BAD_LEN;
        else if (hash_reg != sum_reg)
            verdict_status = STATUS_BAD_SUM;
        else
            verdict_status = STATUS_OK;
    end

    always_comb
    begin
        pos_next   = pos_reg;
        magic_next = magic_reg;
        ver_next   = ver_reg;
        type_next  = type_reg;
        len_next   = len_reg;
        sum_next   = sum_reg;
        hash_next  = hash_reg;
        count_next = count_reg;

        if (cmd.take)
        begin
            if (in_header)
            begin
                if (pos_reg < POS_VERSION)
                    magic_next = {s_tdata, magic_reg[WORD_W-1:BYTE_W]};
                else if (pos_reg == POS_VERSION)
                    ver_next = s_tdata;
                else if (pos_reg == POS_TYPE)
                begin
                    type_next = s_tdata;
                    hash_next = fnv_fold(hash_reg, s_tdata);
                end
                else if (pos_reg < POS_CHECK)
                    len_next = {s_tdata, len_reg[WORD_W-1:BYTE_W]};
                else
                    sum_next = {s_tdata, sum_reg[WORD_W-1:BYTE_W]};
                pos_next = pos_reg + 4'd1;
            end
            else
            begin
                hash_next = fnv_fold(hash_reg, s_tdata);
                if (count_reg != COUNT_MAX)
                    count_next = count_reg + 33'd1;
            end
        end
        else if (cmd.fold_version)
            hash_next = fnv_fold(hash_reg, ver_reg);
        else if (cmd.load_verdict)
        begin
            pos_next   = '0;
            magic_next = '0;
            ver_next   = '0;
            type_next  = '0;
            len_next   = '0;
            sum_next   = '0;
            hash_next  = FNV_BASIS;
            count_next = '0;
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg && !m_tready;
        out_kind_next   = out_kind_reg;
        out_byte_next   = out_byte_reg;
        out_type_next   = out_type_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        if (take_payload)
        begin
            out_valid_next  = 1'b1;
            out_kind_next   = KIND_PAYLOAD;
            out_byte_next   = s_tdata;
            out_type_next   = '0;
            out_status_next = STATUS_OK;
            out_last_next   = !s_tlast;
        end
        else if (cmd.load_verdict)
        begin
            out_valid_next  = 1'b1;
            out_kind_next   = KIND_VERDICT;
            out_byte_next   = '0;
            out_type_next   = verdict_type;
            out_status_next = verdict_status;
            out_last_next   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_ver_reg   <= VERSION_RST;
            pos_reg       <= '0;
            magic_reg     <= '0;
            ver_reg       <= '0;
            type_reg      <= '0;
            len_reg       <= '0;
            sum_reg       <= '0;
            hash_reg      <= FNV_BASIS;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                exp_ver_reg <= cfg_wr_data;
            pos_reg       <= pos_next;
            magic_reg     <= magic_next;
            ver_reg       <= ver_next;
            type_reg      <= type_next;
            len_reg       <= len_next;
            sum_reg       <= sum_next;
            hash_reg      <= hash_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_kind_reg   <= out_kind_next;
        out_byte_reg   <= out_byte_next;
        out_type_reg   <= out_type_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(M_TDATA_W-2*BYTE_W-STATUS_W){1'b0}},
                       out_status_reg, out_type_reg, out_byte_reg};

`ifndef SYNTH
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= HDR_BYTES)
        else $error("header position beyond header length");

    // The output register is only loaded when it is free.
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (take_payload || cmd.load_verdict) |-> dp_status.out_free)
        else $error("output register overwritten");

    // A verdict always clears the per-packet state for the next packet.
    a_clear_after_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_verdict |=> (pos_reg == '0) && (count_reg == '0) && (hash_reg == FNV_BASIS))
        else $error("packet state not cleared after verdict");

    a_verdict_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_kind_reg == KIND_VERDICT) |-> out_last_reg)
        else $error("verdict item without run end");
`endif

endmodule

// ===== design/packet_header_parse_fnv_check.sv =====
// Top level of the packet header parser with FNV-1a check.
// Depends on phpfc_pkg, phpfc_ctrl and phpfc_dp.
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+--------------------------------------------
//  s_      | in  | s_tvalid/s_tready | s_tdata = data_byte, s_tlast = final_byte
//  m_      | out | m_tvalid/m_tready | m_tdata, m_tuser = item_kind, m_tlast = run_end
//  cfg_    | in  | cfg_wr_en         | cfg_wr_data = expected_version
//
// A payload byte or a plain header byte is taken from S_IDLE; after the type byte the
// controller passes through S_FOLD, where the version byte is folded into the hash
// by the FNV fold. After a final byte the verdict is loaded from S_VERD.
// Reset is asynchronous, active low, and restores the FNV offset basis and version 1.
// A stalled output register holds back the input until it drains.
module packet_header_parse_fnv_check (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,     // [7:0] payload_byte, [15:8] packet_type,
                                     // [18:16] status, [23:19] zero
    output logic        m_tuser,     // [0] item_kind
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data
);
    import phpfc_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t dp_status;

    phpfc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tlast   (s_tlast),
        .s_tready  (s_tready),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    phpfc_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .dp_status   (dp_status),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

// ===== tb/packet_header_parse_fnv_check_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for packet_header_parse_fnv_check: drives framed packets with
// random faults and stalls, predicts payload and verdict transactions, checks them in order.
// Depends on phpfc_pkg and the packet_header_parse_fnv_check RTL.
module packet_header_parse_fnv_check_tb;
    import phpfc_pkg::*;

    localparam logic [WORD_W-1:0] FNV_PRIME   = 32'd16777619;
    localparam int                STALL_LIMIT = 1000;
    localparam int                SETTLE      = 8;

    typedef enum int {
        FAULT_NONE,
        FAULT_MAGIC,
        FAULT_VERSION,
        FAULT_LENGTH,
        FAULT_SUM
    } fault_t;

    typedef struct {
        logic                kind;
        logic [BYTE_W-1:0]   payload;
        logic [BYTE_W-1:0]   ptype;
        logic [STATUS_W-1:0] status;
        logic                run_end;
    } deframe_item_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_wr_en;
    logic [7:0]  cfg_wr_data;

    // Predicted state of the parser.
    logic [POS_W-1:0]   hdr_pos;
    logic [WORD_W-1:0]  magic_w;
    logic [BYTE_W-1:0]  ver_b;
    logic [BYTE_W-1:0]  type_b;
    logic [WORD_W-1:0]  len_w;
    logic [WORD_W-1:0]  sum_w;
    logic [WORD_W-1:0]  hash_w;
    logic [COUNT_W-1:0] pay_cnt;
    logic [BYTE_W-1:0]  want_version;

    deframe_item_t awaited_items[$];
    int            errors;
    int            bytes_sent;
    int            idle_cycles;
    int            stall_left;
    bit            gaps_on;

    packet_header_parse_fnv_check uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #1 clk = ~clk;

    function automatic logic [WORD_W-1:0] fnv_mix(input logic [WORD_W-1:0] h,
                                                  input logic [BYTE_W-1:0] b);
        begin
            fnv_mix = (h ^ {24'd0, b}) * FNV_PRIME;
        end
    endfunction

    function automatic logic [WORD_W-1:0] shift_le(input logic [WORD_W-1:0] w,
                                                   input logic [BYTE_W-1:0] b);
        begin
            shift_le = {b, w[31:8]};
        end
    endfunction

    task automatic clear_packet();
        begin
            hdr_pos = '0;
            magic_w = '0;
            ver_b   = '0;
            type_b  = '0;
            len_w   = '0;
            sum_w   = '0;
            hash_w  = FNV_BASIS;
            pay_cnt = '0;
        end
    endtask

    // Advances the predicted parser by one accepted byte and queues what it emits.
    task automatic deframe_byte(input logic [BYTE_W-1:0] b, input logic is_last);
        deframe_item_t r;
        begin
            if (hdr_pos < HDR_BYTES)
            begin
                if (hdr_pos < POS_VERSION)
                    magic_w = shift_le(magic_w, b);
                else if (hdr_pos == POS_VERSION)
                    ver_b = b;
                else if (hdr_pos == POS_TYPE)
                begin
                    // The type byte is hashed first, then the version byte.
                    type_b = b;
                    hash_w = fnv_mix(fnv_mix(hash_w, type_b), ver_b);
                end
                else if (hdr_pos < POS_CHECK)
                    len_w = shift_le(len_w, b);
                else
                    sum_w = shift_le(sum_w, b);
                hdr_pos = hdr_pos + 4'd1;
            end
            else
            begin
                hash_w = fnv_mix(hash_w, b);
                if (pay_cnt != COUNT_MAX)
                    pay_cnt = pay_cnt + 33'd1;
                r.kind    = KIND_PAYLOAD;
                r.payload = b;
                r.ptype   = '0;
                r.status  = STATUS_OK;
                r.run_end = !is_last;
                awaited_items = {awaited_items, r};
            end
            if (is_last)
            begin
                r.kind    = KIND_VERDICT;
                r.payload = '0;
                r.ptype   = '0;
                r.run_end = 1'b1;
                if (hdr_pos < HDR_BYTES)
                    r.status = STATUS_TRUNCATED;
                else
                begin
                    r.ptype = type_b;
                    if (magic_w != MAGIC_WORD)
                        r.status = STATUS_BAD_MAGIC;
                    else if (ver_b != want_version)
                        r.status = STATUS_BAD_VER;
                    else if (pay_cnt != {1'b0, len_w})
                        r.status = STATUS_BAD_LEN;
                    else if (hash_w != sum_w)
                        r.status = STATUS_BAD_SUM;
                    else
                        r.status = STATUS_OK;
                end
                awaited_items = {awaited_items, r};
                clear_packet();
            end
        end
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        begin
            $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $time, field, got, want);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        deframe_item_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (awaited_items.size() == 0)
                report_mismatch("unexpected transaction", 32'(m_tdata), 32'd0);
            else
            begin
                want = awaited_items.pop_front();
                if (m_tuser !== want.kind)
                    report_mismatch("item_kind", 32'(m_tuser), 32'(want.kind));
                if (m_tdata[7:0] !== want.payload)
                    report_mismatch("payload_byte", 32'(m_tdata[7:0]), 32'(want.payload));
                if (m_tdata[15:8] !== want.ptype)
                    report_mismatch("packet_type", 32'(m_tdata[15:8]), 32'(want.ptype));
                if (m_tdata[18:16] !== want.status)
                    report_mismatch("status", 32'(m_tdata[18:16]), 32'(want.status));
                if (m_tdata[23:19] !== 5'd0)
                    report_mismatch("tdata padding", 32'(m_tdata[23:19]), 32'd0);
                if (m_tlast !== want.run_end)
                    report_mismatch("run_end", 32'(m_tlast), 32'(want.run_end));
            end
        end
    end

    // Receiver back-pressure in random bursts.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end
        else if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 14) - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic is_last);
        int gap;
        begin
            if (gaps_on && $urandom_range(0, 4) == 0)
            begin
                gap = $urandom_range(1, 14);
                repeat (gap)
                begin
                    @(negedge clk);
                    s_tvalid <= 1'b0;
                end
            end
            @(negedge clk);
            s_tvalid <= 1'b1;
            s_tdata  <= b;
            s_tlast  <= is_last;
            do @(posedge clk); while (!s_tready);
            deframe_byte(b, is_last);
            bytes_sent++;
        end
    endtask

    // Waits until every predicted transaction has been seen, then lets the block settle.
    task automatic wait_drain();
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            while (awaited_items.size() != 0)
                @(posedge clk);
            repeat (SETTLE) @(posedge clk);
        end
    endtask

    task automatic write_version(input logic [7:0] v);
        begin
            wait_drain();
            @(negedge clk);
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= v;
            @(negedge clk);
            cfg_wr_en   <= 1'b0;
            want_version = v;
        end
    endtask

    // Builds a packet with one optional fault and sends it; a cut > 0 below its length truncates it.
    task automatic send_packet(input fault_t fault, input logic [7:0] ptype,
                               input int plen, input int cut);
        logic [7:0]  frame[$];
        logic [7:0]  ver;
        logic [31:0] magic;
        logic [31:0] dlen;
        logic [31:0] sum;
        logic [7:0]  b;
        int          n;
        begin
            ver   = want_version;
            magic = MAGIC_WORD;
            dlen  = plen;
            if (fault == FAULT_VERSION)
                ver = ver ^ 8'($urandom_range(1, 255));
            if (fault == FAULT_MAGIC)
                magic = magic ^ (32'd1 << $urandom_range(0, 31));
            if (fault == FAULT_LENGTH)
                dlen = dlen ^ (32'd1 << $urandom_range(0, 31));
            sum = fnv_mix(fnv_mix(FNV_BASIS, ptype), ver);
            for (int i = 0; i < plen; i++)
            begin
                b = 8'($urandom);
                sum = fnv_mix(sum, b);
                frame = {frame, b};
            end
            if (fault == FAULT_SUM)
                sum = sum ^ (32'd1 << $urandom_range(0, 31));
            for (int i = 3; i >= 0; i--)
                frame.push_front(sum[8*i +: 8]);
            for (int i = 3; i >= 0; i--)
                frame.push_front(dlen[8*i +: 8]);
            frame.push_front(ptype);
            frame.push_front(ver);
            for (int i = 3; i >= 0; i--)
                frame.push_front(magic[8*i +: 8]);
            n = (cut > 0 && cut < frame.size()) ? cut : frame.size();
            for (int i = 0; i < n; i++)
                send_byte(frame[i], i == n - 1);
        end
    endtask

    task automatic send_noise();
        int n;
        begin
            n = $urandom_range(1, 30);
            for (int i = 0; i < n; i++)
                send_byte(8'($urandom), i == n - 1);
        end
    endtask

    task automatic send_random_packet();
        int     pick;
        int     plen;
        fault_t fault;
        begin
            pick  = $urandom_range(0, 19);
            fault = FAULT_NONE;
            plen  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 200)
                                                : $urandom_range(0, 24);
            case (pick)
                11:      fault = FAULT_MAGIC;
                12, 13:  fault = FAULT_VERSION;
                14, 15:  fault = FAULT_LENGTH;
                16, 17:  fault = FAULT_SUM;
                default: fault = FAULT_NONE;
            endcase
            if (pick == 18)
                send_noise();
            else if (pick == 9 || pick == 10)
                send_packet(FAULT_NONE, 8'($urandom), plen, $urandom_range(1, 13));
            else
                send_packet(fault, 8'($urandom), plen, 0);
        end
    endtask

    // Header boundaries under the reset version: one-byte packet, cut after the
    // type byte, and a header with an empty payload.
    task automatic test_header_boundaries();
        begin
            gaps_on = 1'b1;
            send_byte(8'hFF, 1'b1);
            send_packet(FAULT_NONE, 8'hFF, 0, 6);
            send_packet(FAULT_NONE, 8'h00, 0, 0);
        end
    endtask

    task automatic test_version_extremes();
        logic [7:0] v;
        begin
            for (int k = 0; k < 3; k++)
            begin
                v = (k == 0) ? 8'h00 : (k == 1) ? 8'hFF : 8'($urandom);
                write_version(v);
                send_packet(FAULT_NONE, 8'($urandom), $urandom_range(0, 8), 0);
                send_packet(FAULT_VERSION, 8'($urandom), $urandom_range(0, 8), 0);
                send_packet(FAULT_NONE, 8'($urandom), $urandom_range(0, 8), 0);
            end
        end
    endtask

    task automatic test_fault_mix(input int target);
        int pick;
        begin
            while (bytes_sent < target)
            begin
                if ($urandom_range(0, 24) == 0)
                begin
                    pick = $urandom_range(0, 5);
                    write_version(pick == 0 ? 8'h00 : pick == 1 ? 8'hFF :
                                  pick == 2 ? VERSION_RST : 8'($urandom));
                end
                if ($urandom_range(0, 5) == 0)
                    gaps_on = !gaps_on;
                send_random_packet();
            end
        end
    endtask

    task automatic test_streaming_no_gaps(input int target);
        begin
            gaps_on = 1'b0;
            write_version(VERSION_RST);
            while (bytes_sent < target)
                send_random_packet();
        end
    endtask

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        errors       = 0;
        bytes_sent   = 0;
        gaps_on      = 1'b0;
        want_version = VERSION_RST;
        clear_packet();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_header_boundaries();
        test_version_extremes();
        test_fault_mix(1250);
        test_streaming_no_gaps(1400);

        wait_drain();
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/phpfc_pkg.sv
design/phpfc_ctrl.sv
design/phpfc_dp.sv
design/packet_header_parse_fnv_check.sv
tb/packet_header_parse_fnv_check_tb.sv
